// ===== sv/rdmfp_pkg.sv =====
// Package for the RDM frame parser: result layout and frame offsets.
package rdmfp_pkg;

  localparam int unsigned IdxW = 9;
  localparam logic [IdxW-1:0] IdxMax = '1;

  localparam logic [IdxW-1:0] OfsLength  = 9'd2;
  localparam logic [IdxW-1:0] OfsDest    = 9'd3;
  localparam logic [IdxW-1:0] OfsSrc     = 9'd9;
  localparam logic [IdxW-1:0] OfsTn      = 9'd15;
  localparam logic [IdxW-1:0] OfsRespTyp = 9'd16;
  localparam logic [IdxW-1:0] OfsMsgCnt  = 9'd17;
  localparam logic [IdxW-1:0] OfsSubDev  = 9'd18;
  localparam logic [IdxW-1:0] OfsCmdCls  = 9'd20;
  localparam logic [IdxW-1:0] OfsPid     = 9'd21;
  localparam logic [IdxW-1:0] OfsPdl     = 9'd23;
  localparam logic [IdxW-1:0] OfsPd      = 9'd24;
  localparam int unsigned UidBytes = 6;

  // Packed from MSB down; dest_uid lands in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic        checksum_ok;
    logic [15:0] checksum_expected;
    logic [7:0]  frame_length;
    logic [7:0]  param_data_length;
    logic [15:0] parameter_id;
    logic [7:0]  command_class;
    logic [15:0] sub_device;
    logic [7:0]  message_count;
    logic [7:0]  response_type;
    logic [7:0]  transaction_number;
    logic [47:0] src_uid;
    logic [47:0] dest_uid;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

// ===== sv/rdmfp_parse.sv =====
// Frame state, header capture and checksum accumulation, one byte per step.
module rdmfp_parse (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    frame_start,
  output logic                    done,
  output rdmfp_pkg::result_t      result
);

  logic [rdmfp_pkg::IdxW-1:0] byte_index, byte_index_next;
  logic                       frame_active, frame_active_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [7:0]  pdl_reg, pdl_reg_next;
  logic [47:0] dest_reg, dest_reg_next;
  logic [47:0] src_reg, src_reg_next;
  logic [7:0]  tn_reg, tn_reg_next;
  logic [7:0]  rt_reg, rt_reg_next;
  logic [7:0]  mc_reg, mc_reg_next;
  logic [7:0]  cc_reg, cc_reg_next;
  logic [15:0] subdev_reg, subdev_reg_next;
  logic [15:0] pid_reg, pid_reg_next;
  logic [7:0]  checksum_high, checksum_high_next;

  logic [rdmfp_pkg::IdxW-1:0] idx, pos_pd, pos_len, pos;
  logic                       live;

  always_comb begin
    live = frame_start || frame_active;
    idx  = frame_start ? '0 : byte_index;
    running_sum_next   = frame_start ? '0 : running_sum;
    length_reg_next    = frame_start ? '0 : length_reg;
    pdl_reg_next       = frame_start ? '0 : pdl_reg;
    dest_reg_next      = frame_start ? '0 : dest_reg;
    src_reg_next       = frame_start ? '0 : src_reg;
    tn_reg_next        = frame_start ? '0 : tn_reg;
    rt_reg_next        = frame_start ? '0 : rt_reg;
    mc_reg_next        = frame_start ? '0 : mc_reg;
    cc_reg_next        = frame_start ? '0 : cc_reg;
    subdev_reg_next    = frame_start ? '0 : subdev_reg;
    pid_reg_next       = frame_start ? '0 : pid_reg;
    checksum_high_next = frame_start ? '0 : checksum_high;

    pos_pd  = rdmfp_pkg::OfsPd + {1'b0, pdl_reg_next};
    pos_len = {1'b0, length_reg_next};
    pos     = (pos_len > pos_pd) ? pos_len : pos_pd;

    result.pad                = '0;
    result.dest_uid           = dest_reg_next;
    result.src_uid            = src_reg_next;
    result.transaction_number = tn_reg_next;
    result.response_type      = rt_reg_next;
    result.message_count      = mc_reg_next;
    result.sub_device         = subdev_reg_next;
    result.command_class      = cc_reg_next;
    result.parameter_id       = pid_reg_next;
    result.param_data_length  = pdl_reg_next;
    result.frame_length       = length_reg_next;
    result.checksum_expected  = running_sum_next;
    result.checksum_ok        = ({checksum_high_next, data_byte} == running_sum_next);

    done = 1'b0;
    frame_active_next = live;

    if (idx == rdmfp_pkg::OfsLength) begin
      length_reg_next = data_byte;
    end else if (idx >= rdmfp_pkg::OfsDest && idx < rdmfp_pkg::OfsSrc) begin
      dest_reg_next = {dest_reg_next[39:0], data_byte};
    end else if (idx >= rdmfp_pkg::OfsSrc && idx < rdmfp_pkg::OfsTn) begin
      src_reg_next = {src_reg_next[39:0], data_byte};
    end else if (idx == rdmfp_pkg::OfsTn) begin
      tn_reg_next = data_byte;
    end else if (idx == rdmfp_pkg::OfsRespTyp) begin
      rt_reg_next = data_byte;
    end else if (idx == rdmfp_pkg::OfsMsgCnt) begin
      mc_reg_next = data_byte;
    end else if (idx >= rdmfp_pkg::OfsSubDev && idx < rdmfp_pkg::OfsCmdCls) begin
      subdev_reg_next = {subdev_reg_next[7:0], data_byte};
    end else if (idx == rdmfp_pkg::OfsCmdCls) begin
      cc_reg_next = data_byte;
    end else if (idx >= rdmfp_pkg::OfsPid && idx < rdmfp_pkg::OfsPdl) begin
      pid_reg_next = {pid_reg_next[7:0], data_byte};
    end else if (idx == rdmfp_pkg::OfsPdl) begin
      pdl_reg_next = data_byte;
    end

    if (idx < rdmfp_pkg::OfsPd || idx < pos) begin
      running_sum_next = running_sum_next + {8'd0, data_byte};
    end else if (idx == pos) begin
      checksum_high_next = data_byte;
    end else if (idx == pos + 9'd1) begin
      done = live;
      frame_active_next = 1'b0;
    end

    byte_index_next = (idx == rdmfp_pkg::IdxMax) ? idx : idx + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      byte_index   <= '0;
    end else if (step && live) begin
      frame_active <= frame_active_next;
      byte_index   <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      length_reg    <= '0;
      pdl_reg       <= '0;
      dest_reg      <= '0;
      src_reg       <= '0;
      tn_reg        <= '0;
      rt_reg        <= '0;
      mc_reg        <= '0;
      cc_reg        <= '0;
      subdev_reg    <= '0;
      pid_reg       <= '0;
      checksum_high <= '0;
    end else if (step && live) begin
      running_sum   <= running_sum_next;
      length_reg    <= length_reg_next;
      pdl_reg       <= pdl_reg_next;
      dest_reg      <= dest_reg_next;
      src_reg       <= src_reg_next;
      tn_reg        <= tn_reg_next;
      rt_reg        <= rt_reg_next;
      mc_reg        <= mc_reg_next;
      cc_reg        <= cc_reg_next;
      subdev_reg    <= subdev_reg_next;
      pid_reg       <= pid_reg_next;
      checksum_high <= checksum_high_next;
    end
  end

endmodule

// ===== sv/rdm_frame_parser_checksum.sv =====
// Top level of the RDM frame parser with checksum check.
//
// Input stream: one frame byte per request on s_axis; tuser[0] marks the
// start code (first byte) of a frame. Output stream: one request per frame on
// m_axis, issued when the second checksum byte arrives, carrying the header
// fields, the computed 16-bit sum and the compare flag.
//
// The accepted second checksum byte passes the input register, then the
// result register, before m_axis_tvalid is raised. Throughput: one byte per
// cycle while m_axis is not stalled, set by the single parse stage; the byte
// counter and sum adder finish in it. Bytes outside a frame, trailer bytes and
// frames cut short by a new start give no output.
//
// Reset clears the frame state and both pipeline valid flags. When the
// receiver holds m_axis_tready low with a result pending, the parse stage
// stops, the input register fills and s_axis_tready then drops; nothing is
// lost or reordered.
module rdm_frame_parser_checksum (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,  // [0] frame_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [47:0] dest_uid, [95:48] src_uid, [103:96] transaction_number,
  // [111:104] response_type, [119:112] message_count, [135:120] sub_device,
  // [143:136] command_class, [159:144] parameter_id,
  // [167:160] param_data_length, [175:168] frame_length,
  // [191:176] checksum_expected, [192] checksum_ok, [199:193] zero
  output logic [199:0] m_axis_tdata
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;
  logic       step;
  logic       done;
  rdmfp_pkg::result_t result;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser[0];
    end
  end

  rdmfp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .frame_start(in_start),
    .done       (done),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= step && done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && done) begin
      m_axis_tdata <= result;
    end
  end

endmodule

// ===== sv/rdmfp_checker.sv =====
// Port-level checker for the RDM frame parser, bound to the top level.
module rdmfp_props (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output free");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a byte two cycles earlier");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[199:193] == 7'd0)
    else $error("padding bits set");

endmodule

bind rdm_frame_parser_checksum rdmfp_props u_rdmfp_props (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== verif/rdmfp_checker.sv =====
// Checker for the RDM frame parser: tracks accepted frame bytes, predicts results, compares.
module rdmfp_checker
  import rdmfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] frame_start
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [199:0] m_axis_tdata,   // result_t, dest_uid in the lowest bits
  output int           mismatches,
  output int           outstanding,
  output int           results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state as the frame goes by
  logic [IdxW-1:0] byte_idx;
  logic            in_frame;
  logic [15:0]     sum16;
  logic [7:0]      msg_len;
  logic [7:0]      pd_len;
  logic [47:0]     dst;
  logic [47:0]     src;
  logic [7:0]      txn;
  logic [7:0]      rsp_type;
  logic [7:0]      msg_cnt;
  logic [7:0]      cmd_cls;
  logic [15:0]     subdev;
  logic [15:0]     pid;
  logic [7:0]      cks_hi;

  result_t expected_frames[$];

  task automatic restart_frame();
    byte_idx = '0;
    sum16    = '0;
    msg_len  = '0;
    pd_len   = '0;
    dst      = '0;
    src      = '0;
    txn      = '0;
    rsp_type = '0;
    msg_cnt  = '0;
    cmd_cls  = '0;
    subdev   = '0;
    pid      = '0;
    cks_hi   = '0;
  endtask

  task automatic parse_rdm_byte(input logic [7:0] b, input logic st);
    int      ck_pos;
    result_t r;
    if (st) begin
      restart_frame();
      in_frame = 1'b1;
    end else if (!in_frame) begin
      return;
    end

    if (byte_idx == OfsLength) begin
      msg_len = b;
    end else if (byte_idx >= OfsDest && byte_idx < OfsSrc) begin
      dst = {dst[39:0], b};
    end else if (byte_idx >= OfsSrc && byte_idx < OfsTn) begin
      src = {src[39:0], b};
    end else if (byte_idx == OfsTn) begin
      txn = b;
    end else if (byte_idx == OfsRespTyp) begin
      rsp_type = b;
    end else if (byte_idx == OfsMsgCnt) begin
      msg_cnt = b;
    end else if (byte_idx == OfsSubDev || byte_idx == OfsSubDev + 9'd1) begin
      subdev = {subdev[7:0], b};
    end else if (byte_idx == OfsCmdCls) begin
      cmd_cls = b;
    end else if (byte_idx == OfsPid || byte_idx == OfsPid + 9'd1) begin
      pid = {pid[7:0], b};
    end else if (byte_idx == OfsPdl) begin
      pd_len = b;
    end

    if (byte_idx < OfsPd) begin
      sum16 = sum16 + 16'(b);
    end else begin
      // checksum sits after the larger of header+PD and the message length
      ck_pos = int'(OfsPd) + int'(pd_len);
      if (int'(msg_len) > ck_pos) ck_pos = int'(msg_len);
      if (int'(byte_idx) < ck_pos) begin
        sum16 = sum16 + 16'(b);
      end else if (int'(byte_idx) == ck_pos) begin
        cks_hi = b;
      end else if (int'(byte_idx) == ck_pos + 1) begin
        r = '0;
        r.dest_uid           = dst;
        r.src_uid            = src;
        r.transaction_number = txn;
        r.response_type      = rsp_type;
        r.message_count      = msg_cnt;
        r.sub_device         = subdev;
        r.command_class      = cmd_cls;
        r.parameter_id       = pid;
        r.param_data_length  = pd_len;
        r.frame_length       = msg_len;
        r.checksum_expected  = sum16;
        r.checksum_ok        = ({cks_hi, b} == sum16);
        expected_frames.push_back(r);
        in_frame = 1'b0;
      end
    end

    if (byte_idx != IdxMax) byte_idx = byte_idx + 9'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 50)
      $display("%0t ns: mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch("result with no frame pending", got.checksum_expected, '0);
      return;
    end
    want = expected_frames.pop_front();
    results_checked++;
    if (got.dest_uid !== want.dest_uid)
      report_mismatch("dest_uid", got.dest_uid, want.dest_uid);
    if (got.src_uid !== want.src_uid)
      report_mismatch("src_uid", got.src_uid, want.src_uid);
    if (got.transaction_number !== want.transaction_number)
      report_mismatch("transaction_number", got.transaction_number, want.transaction_number);
    if (got.response_type !== want.response_type)
      report_mismatch("response_type", got.response_type, want.response_type);
    if (got.message_count !== want.message_count)
      report_mismatch("message_count", got.message_count, want.message_count);
    if (got.sub_device !== want.sub_device)
      report_mismatch("sub_device", got.sub_device, want.sub_device);
    if (got.command_class !== want.command_class)
      report_mismatch("command_class", got.command_class, want.command_class);
    if (got.parameter_id !== want.parameter_id)
      report_mismatch("parameter_id", got.parameter_id, want.parameter_id);
    if (got.param_data_length !== want.param_data_length)
      report_mismatch("param_data_length", got.param_data_length, want.param_data_length);
    if (got.frame_length !== want.frame_length)
      report_mismatch("frame_length", got.frame_length, want.frame_length);
    if (got.checksum_expected !== want.checksum_expected)
      report_mismatch("checksum_expected", got.checksum_expected, want.checksum_expected);
    if (got.checksum_ok !== want.checksum_ok)
      report_mismatch("checksum_ok", got.checksum_ok, want.checksum_ok);
    if (got.pad !== want.pad)
      report_mismatch("pad", got.pad, want.pad);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_frame = 1'b0;
      restart_frame();
      expected_frames.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(result_t'(m_axis_tdata));
      if (s_axis_tvalid && s_axis_tready) parse_rdm_byte(s_axis_tdata, s_axis_tuser[0]);
    end
    outstanding = expected_frames.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the RDM frame parser: clock, reset, frame stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
  logic [0:0]   s_axis_tuser = '0;   // [0] frame_start
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;        // result_t, dest_uid in the lowest bits

  int mismatches;
  int outstanding;
  int results_checked;

  int tx_idle_pct = 24;
  int rx_idle_pct = 88;
  int rx_hold_req = 0;
  int frame_bytes = 0;
  int frames_sent = 0;
  int frames_cut  = 0;

  rdm_frame_parser_checksum DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rdmfp_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always #5 clk = ~clk;

  // receiver: random backpressure, plus long holds on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !rst && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still pending", outstanding);
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] fill_byte(input fill_mode_t fill_mode);
    case (fill_mode)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= b;
    s_axis_tuser[0] <= st;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // cut_at > 0 sends only that many bytes; the next start then cuts the frame
  task automatic send_frame(input int pdl, input int len, input fill_mode_t fill_mode,
                            input bit good_ck, input int cut_at, input int trailer);
    logic [7:0]  fb[$];
    logic [15:0] sum;
    logic [15:0] ck;
    int          ck_at;
    int          n_send;
    ck_at = int'(rdmfp_pkg::OfsPd) + pdl;
    if (len > ck_at) ck_at = len;
    for (int k = 0; k < ck_at; k++) fb.push_back(fill_byte(fill_mode));
    fb[rdmfp_pkg::OfsLength] = 8'(len);
    fb[rdmfp_pkg::OfsPdl]    = 8'(pdl);
    sum = '0;
    foreach (fb[k]) sum = sum + 16'(fb[k]);
    ck = good_ck ? sum : sum ^ 16'($urandom_range(1, 16'hFFFF));
    fb.push_back(ck[15:8]);
    fb.push_back(ck[7:0]);
    n_send = (cut_at > 0) ? cut_at : fb.size();
    for (int k = 0; k < n_send; k++) begin
      send_byte(fb[k], k == 0);
      frame_bytes++;
    end
    frames_sent++;
    if (cut_at > 0) frames_cut++;
    repeat (trailer) send_byte(fill_byte(FILL_RANDOM), 1'b0);
  endtask

  task automatic send_random_frame();
    int         sel;
    int         pdl;
    int         len;
    int         ck_at;
    int         cut_at;
    fill_mode_t fill_mode;
    if ($urandom_range(99) < 5)
      repeat ($urandom_range(1, 3)) send_byte(fill_byte(FILL_RANDOM), 1'b0);
    sel = $urandom_range(99);
    if (sel < 80)      pdl = $urandom_range(12);
    else if (sel < 97) pdl = $urandom_range(13, 60);
    else               pdl = $urandom_range(200, 255);
    sel = $urandom_range(99);
    if (sel < 65) begin
      len = (int'(rdmfp_pkg::OfsPd) + pdl) % 256;
    end else if (sel < 85) begin
      len = int'(rdmfp_pkg::OfsPd) + pdl + $urandom_range(1, 8);
      if (len > 255) len = 255;
    end else if (sel < 95) begin
      len = $urandom_range(0, (int'(rdmfp_pkg::OfsPd) + pdl > 255) ? 255 :
                              int'(rdmfp_pkg::OfsPd) + pdl);
    end else begin
      len = $urandom_range(255);
    end
    ck_at = int'(rdmfp_pkg::OfsPd) + pdl;
    if (len > ck_at) ck_at = len;
    cut_at = ($urandom_range(99) < 7) ? $urandom_range(1, ck_at + 1) : 0;
    sel = $urandom_range(99);
    fill_mode = (sel < 90) ? FILL_RANDOM : (sel < 95) ? FILL_ZERO : FILL_ONES;
    send_frame(pdl, len, fill_mode, $urandom_range(99) < 85, cut_at,
               ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes outside a frame, a frame cut short, all-ones header with short
    // length and bad checksum plus trailer, zero frame with intron bytes
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_frame(0, 24, FILL_RANDOM, 1'b1, 5, 0);
    send_frame(0, 0, FILL_ONES, 1'b0, 0, 2);
    send_frame(2, 30, FILL_ZERO, 1'b1, 0, 0);
    wait_results_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 24; rx_idle_pct = 88; end
        1:       begin tx_idle_pct = 88; rx_idle_pct = 24; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      if (ph == 2) rx_hold_req = 300;
      while (frame_bytes < (ph + 1) * 550) send_random_frame();
      if (ph == 2) send_frame(255, 255, FILL_RANDOM, 1'b1, 0, 0);
      wait_results_drained();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d frame bytes in %0d frames (%0d cut short), %0d results checked",
             frame_bytes, frames_sent, frames_cut, results_checked);
    $display("idle mixes 24/88, 88/24 and none, with one long receiver hold");
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rdmfp_pkg.sv
sv/rdmfp_parse.sv
sv/rdm_frame_parser_checksum.sv
sv/rdmfp_checker.sv
verif/rdmfp_checker.sv
verif/tb_top.sv
